### hdl/ipms_pkg.sv
// Shared types, constants and helpers for the ignition power mode sequencer.
package ipms_pkg;

  localparam int VOLT_BITS     = 12;
  localparam int TIMER_BITS    = 16;
  localparam int EL_BITS       = 8;
  localparam int IDX_BITS      = 4;
  localparam int CFG_DATA_BITS = 16;

  localparam int IN_BITS        = VOLT_BITS + EL_BITS + 4;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 10;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TIMER_BITS-1:0] GOOD_DWELL_MS = TIMER_BITS'(100);
  localparam logic [TIMER_BITS-1:0] INIT_DWELL_MS = TIMER_BITS'(500);
  localparam logic [TIMER_BITS-1:0] WAIT_DWELL_MS = TIMER_BITS'(100);

  // register indexes
  localparam logic [IDX_BITS-1:0] CFG_ERR_HIGH   = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] CFG_ERR_LOW    = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] CFG_OK_HIGH    = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] CFG_OK_LOW     = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] CFG_SLEEP_VOLT = IDX_BITS'(4);
  localparam logic [IDX_BITS-1:0] CFG_WAKE_VOLT  = IDX_BITS'(5);
  localparam logic [IDX_BITS-1:0] CFG_HIGH_FAULT = IDX_BITS'(6);
  localparam logic [IDX_BITS-1:0] CFG_LOW_FAULT  = IDX_BITS'(7);

  // power_mode output codes
  localparam logic [2:0] PM_INIT    = 3'd0;
  localparam logic [2:0] PM_WORK    = 3'd1;
  localparam logic [2:0] PM_OFF     = 3'd2;
  localparam logic [2:0] PM_STANDBY = 3'd3;
  localparam logic [2:0] PM_WAIT    = 3'd4;
  localparam logic [2:0] PM_SLEEP   = 3'd5;

  typedef enum logic [5:0] {
    MODE_INIT    = 6'b000001,
    MODE_WORK    = 6'b000010,
    MODE_OFF     = 6'b000100,
    MODE_STANDBY = 6'b001000,
    MODE_WAIT    = 6'b010000,
    MODE_SLEEP   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [VOLT_BITS-1:0]  err_high;
    logic [VOLT_BITS-1:0]  err_low;
    logic [VOLT_BITS-1:0]  ok_high;
    logic [VOLT_BITS-1:0]  ok_low;
    logic [VOLT_BITS-1:0]  sleep_volt;
    logic [VOLT_BITS-1:0]  wake_volt;
    logic [TIMER_BITS-1:0] high_fault_ms;
    logic [TIMER_BITS-1:0] low_fault_ms;
  } cfg_t;

  typedef struct packed {
    logic                  volt_fault;
    logic                  qualified;
    logic [TIMER_BITS-1:0] good_timer;
    logic [TIMER_BITS-1:0] fault_timer;
  } qual_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  permit;
    logic [TIMER_BITS-1:0] mode_timer;
  } seq_t;

  // first member lands in the top bits, so fields are listed high to low
  typedef struct packed {
    logic                 bus_wake;
    logic                 bus_sleep_value;
    logic                 bus_sleep_write;
    logic                 app_sleep_ok;
    logic [EL_BITS-1:0]   elapsed_ms;
    logic [VOLT_BITS-1:0] ign_volt;
  } in_t;

  typedef struct packed {
    logic       wake_reset;
    logic       bus_wake_cmd;
    logic       bus_sleep_cmd;
    logic       net_release;
    logic       net_request;
    logic       mode_changed;
    logic       ign_good;
    logic [2:0] power_mode;
  } out_t;

  localparam cfg_t CFG_RESET = '{
    err_high:      VOLT_BITS'(3200),
    err_low:       VOLT_BITS'(900),
    ok_high:       VOLT_BITS'(3100),
    ok_low:        VOLT_BITS'(950),
    sleep_volt:    VOLT_BITS'(500),
    wake_volt:     VOLT_BITS'(600),
    high_fault_ms: TIMER_BITS'(300),
    low_fault_ms:  TIMER_BITS'(300)
  };

  localparam qual_t QUAL_RESET = '{
    volt_fault:  1'b0,
    qualified:   1'b0,
    good_timer:  '0,
    fault_timer: '0
  };

  localparam seq_t SEQ_RESET = '{
    mode:       MODE_INIT,
    permit:     1'b0,
    mode_timer: '0
  };

  function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] t,
                                                    input logic [EL_BITS-1:0] e);
    logic [TIMER_BITS:0] s;
    s = {1'b0, t} + {{(TIMER_BITS + 1 - EL_BITS){1'b0}}, e};
    return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_WORK:    c = PM_WORK;
      MODE_OFF:     c = PM_OFF;
      MODE_STANDBY: c = PM_STANDBY;
      MODE_WAIT:    c = PM_WAIT;
      MODE_SLEEP:   c = PM_SLEEP;
      default:      c = PM_INIT;
    endcase
    return c;
  endfunction

endpackage

### hdl/ipms_qual.sv
// Ignition qualifier: hysteresis fault window and good/bad dwell timers.
module ipms_qual (
  input  ipms_pkg::cfg_t  cfg,
  input  ipms_pkg::in_t   item,
  input  logic            sleeping,
  input  ipms_pkg::qual_t cur,
  output ipms_pkg::qual_t nxt
);

  logic                            fault;
  logic [ipms_pkg::TIMER_BITS-1:0] gsum;
  logic [ipms_pkg::TIMER_BITS-1:0] fsum;
  logic [ipms_pkg::TIMER_BITS-1:0] lim;

  always_comb begin
    nxt   = cur;
    fault = cur.volt_fault;
    if (item.ign_volt > cfg.err_high || item.ign_volt < cfg.err_low) fault = 1'b1;
    // clear test wins when both hold
    if (item.ign_volt < cfg.ok_high && item.ign_volt > cfg.ok_low) fault = 1'b0;
    gsum = ipms_pkg::sat_add(cur.good_timer, item.elapsed_ms);
    fsum = ipms_pkg::sat_add(cur.fault_timer, item.elapsed_ms);
    lim  = (item.ign_volt > cfg.ok_high) ? cfg.high_fault_ms : cfg.low_fault_ms;
    if (!sleeping) begin
      nxt.volt_fault = fault;
      if (!fault) begin
        nxt.fault_timer = '0;
        nxt.good_timer  = gsum;
        if (gsum >= ipms_pkg::GOOD_DWELL_MS) nxt.qualified = 1'b1;
      end else begin
        nxt.fault_timer = fsum;
        nxt.good_timer  = '0;
        if (fsum >= lim) nxt.qualified = 1'b0;
      end
    end
  end

endmodule

### hdl/ipms_seq.sv
// Power mode sequencer: mode transitions, command pulses and sleep-loop poll.
module ipms_seq (
  input  ipms_pkg::cfg_t  cfg,
  input  ipms_pkg::in_t   item,
  input  ipms_pkg::seq_t  cur,
  input  ipms_pkg::qual_t qual_in,
  output ipms_pkg::seq_t  nxt,
  output ipms_pkg::qual_t qual_out,
  output ipms_pkg::out_t  res
);

  logic                            req;
  logic                            rel;
  logic                            bsleep;
  logic                            bwcmd;
  logic                            wreset;
  logic                            poll;
  logic [ipms_pkg::TIMER_BITS-1:0] msum;

  always_comb begin
    nxt      = cur;
    qual_out = qual_in;
    req      = 1'b0;
    rel      = 1'b0;
    bsleep   = 1'b0;
    bwcmd    = 1'b0;
    wreset   = 1'b0;
    poll     = 1'b0;
    msum     = ipms_pkg::sat_add(cur.mode_timer, item.elapsed_ms);
    if (item.bus_sleep_write) nxt.permit = item.bus_sleep_value;
    case (cur.mode)
      ipms_pkg::MODE_SLEEP: begin
        poll = 1'b1;
      end
      ipms_pkg::MODE_WORK: begin
        if (!qual_in.qualified) nxt.mode = ipms_pkg::MODE_OFF;
      end
      ipms_pkg::MODE_OFF: begin
        if (qual_in.qualified) nxt.mode = ipms_pkg::MODE_WORK;
        if (item.app_sleep_ok && item.ign_volt < cfg.sleep_volt) begin
          rel      = 1'b1;
          nxt.mode = ipms_pkg::MODE_STANDBY;
        end
      end
      ipms_pkg::MODE_STANDBY: begin
        if (qual_in.qualified) begin
          req        = 1'b1;
          nxt.permit = 1'b0;
          nxt.mode   = ipms_pkg::MODE_WORK;
        end
        if (!item.app_sleep_ok) begin
          req        = 1'b1;
          nxt.permit = 1'b0;
          nxt.mode   = ipms_pkg::MODE_OFF;
        end
        if (nxt.permit) begin
          nxt.mode       = ipms_pkg::MODE_WAIT;
          nxt.mode_timer = '0;
          bsleep         = 1'b1;
        end
      end
      ipms_pkg::MODE_WAIT: begin
        nxt.mode_timer = msum;
        if (msum >= ipms_pkg::WAIT_DWELL_MS) begin
          nxt.mode = ipms_pkg::MODE_SLEEP;
          poll     = 1'b1;
        end
      end
      default: begin
        nxt.mode_timer = msum;
        if (msum >= ipms_pkg::INIT_DWELL_MS) begin
          nxt.mode = qual_in.qualified ? ipms_pkg::MODE_WORK : ipms_pkg::MODE_OFF;
        end
      end
    endcase
    // bus wake is checked ahead of ignition wake
    if (poll) begin
      if (item.bus_wake) begin
        nxt.mode       = ipms_pkg::MODE_INIT;
        nxt.permit     = 1'b0;
        nxt.mode_timer = '0;
        bwcmd          = 1'b1;
      end else if (item.ign_volt > cfg.wake_volt) begin
        nxt      = ipms_pkg::SEQ_RESET;
        qual_out = ipms_pkg::QUAL_RESET;
        wreset   = 1'b1;
      end
    end
    res.power_mode    = ipms_pkg::mode_code(nxt.mode);
    res.ign_good      = qual_out.qualified;
    res.mode_changed  = (nxt.mode != cur.mode);
    res.net_request   = req;
    res.net_release   = rel;
    res.bus_sleep_cmd = bsleep;
    res.bus_wake_cmd  = bwcmd;
    res.wake_reset    = wreset;
  end

endmodule

### hdl/ignition_power_mode_sequencer_unit.sv
// Top level of the ignition power mode sequencer: ports, registers and config.
//
//  channel | dir | beat carries
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | one control step (ign_volt, elapsed_ms, sleep permits, wake)
//  m_*     | out | one result per step (mode, ign_good, command pulses)
//  cfg_*   | in  | register write, index 0..7, data in low bits
//
//  A step is held in the input register, then computed and stored in the result
//  register when it advances; one step per cycle while the m side is not stalled.
//  The state update at the input-to-result move sets the rate.
//  Reset is synchronous: config returns to defaults, all state to init.
//  A stalled m side holds its beat; s_tready drops only when both registers
//  are full and m_tready is low.
module ignition_power_mode_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // ign_volt[11:0], elapsed_ms[19:12], app_sleep_ok[20], bus_sleep_write[21],
  // bus_sleep_value[22], bus_wake[23]
  input  logic [ipms_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // power_mode[2:0], ign_good[3], mode_changed[4], net_request[5],
  // net_release[6], bus_sleep_cmd[7], bus_wake_cmd[8], wake_reset[9], zeros above
  output logic [ipms_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipms_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [ipms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  ipms_pkg::cfg_t  cfg;
  ipms_pkg::qual_t qual;
  ipms_pkg::qual_t qual_step;
  ipms_pkg::qual_t qual_next;
  ipms_pkg::seq_t  seq;
  ipms_pkg::seq_t  seq_next;
  ipms_pkg::in_t   in_data;
  ipms_pkg::out_t  res;
  ipms_pkg::out_t  out_data;
  logic            in_valid;
  logic            out_valid;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(ipms_pkg::OUT_TDATA_BITS - ipms_pkg::OUT_BITS){1'b0}}, out_data};

  ipms_qual u_qual (
    .cfg      (cfg),
    .item     (in_data),
    .sleeping (seq.mode == ipms_pkg::MODE_SLEEP),
    .cur      (qual),
    .nxt      (qual_step)
  );

  ipms_seq u_seq (
    .cfg      (cfg),
    .item     (in_data),
    .cur      (seq),
    .qual_in  (qual_step),
    .nxt      (seq_next),
    .qual_out (qual_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      cfg       <= ipms_pkg::CFG_RESET;
      qual      <= ipms_pkg::QUAL_RESET;
      seq       <= ipms_pkg::SEQ_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) begin
        out_valid <= 1'b1;
        qual      <= qual_next;
        seq       <= seq_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          ipms_pkg::CFG_ERR_HIGH:   cfg.err_high      <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_ERR_LOW:    cfg.err_low       <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_OK_HIGH:    cfg.ok_high       <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_OK_LOW:     cfg.ok_low        <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_SLEEP_VOLT: cfg.sleep_volt    <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_WAKE_VOLT:  cfg.wake_volt     <= cfg_data[ipms_pkg::VOLT_BITS-1:0];
          ipms_pkg::CFG_HIGH_FAULT: cfg.high_fault_ms <= cfg_data[ipms_pkg::TIMER_BITS-1:0];
          ipms_pkg::CFG_LOW_FAULT:  cfg.low_fault_ms  <= cfg_data[ipms_pkg::TIMER_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_data <= ipms_pkg::in_t'(s_tdata[ipms_pkg::IN_BITS-1:0]);
    if (advance) out_data <= res;
  end

endmodule

### hdl/ipms_checker.sv
// Port-level checker for the ignition power mode sequencer, bound to the top level.
module ipms_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [ipms_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_wake_reset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[2:0] == ipms_pkg::PM_INIT && !m_tdata[3] && m_tdata[4])
    else $error("wake reset without return to init");

  a_bus_wake: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[2:0] == ipms_pkg::PM_INIT && m_tdata[4] && !m_tdata[9])
    else $error("bus wake command outside a wake to init");

  a_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> m_tdata[2:0] == ipms_pkg::PM_STANDBY && !m_tdata[5])
    else $error("net release outside entry to standby");

  a_bus_sleep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |-> m_tdata[2:0] == ipms_pkg::PM_WAIT && m_tdata[4])
    else $error("bus sleep command outside entry to standby wait");

endmodule

bind ignition_power_mode_sequencer_unit ipms_checker u_ipms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/tb_ignition_power_mode_sequencer_unit.sv
// Self-checking testbench for the ignition power mode sequencer: directed and random steps.
`timescale 1ns / 1ps

module tb_ignition_power_mode_sequencer_unit;

  typedef enum {VC_ANY, VC_GOOD, VC_LOW_ERR, VC_HIGH_ERR, VC_SLEEPY, VC_WAKE, VC_NEAR} volt_class_t;
  typedef enum {PROF_SLEEP, PROF_DRIVE, PROF_NOISE} step_profile_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [ipms_pkg::IN_TDATA_BITS-1:0]  s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [ipms_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [ipms_pkg::IDX_BITS-1:0]       cfg_index;
  logic [ipms_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  ignition_power_mode_sequencer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's registers and sequencer state
  ipms_pkg::cfg_t                  cfg_q;
  logic [2:0]                      mode_q;
  logic                            fault_q;
  logic                            qual_q;
  logic                            permit_q;
  logic [ipms_pkg::TIMER_BITS-1:0] good_tmr;
  logic [ipms_pkg::TIMER_BITS-1:0] fault_tmr;
  logic [ipms_pkg::TIMER_BITS-1:0] mode_tmr;

  ipms_pkg::out_t pending_results[$];
  int   err_count  = 0;
  int   result_idx = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   hold_req   = 0;
  int   hold_left  = 0;

  task automatic flag_error(string msg);
    if (err_count < 40) $display("ERROR: %s", msg);
    err_count++;
  endtask

  function automatic logic [ipms_pkg::TIMER_BITS-1:0] timer_add(
      logic [ipms_pkg::TIMER_BITS-1:0] t, logic [ipms_pkg::EL_BITS-1:0] el);
    int sum;
    sum = int'(t) + int'(el);
    return (sum > 65535) ? 16'hFFFF : sum[ipms_pkg::TIMER_BITS-1:0];
  endfunction

  function automatic void clear_seq_state();
    mode_q    = ipms_pkg::PM_INIT;
    fault_q   = 1'b0;
    qual_q    = 1'b0;
    permit_q  = 1'b0;
    good_tmr  = '0;
    fault_tmr = '0;
    mode_tmr  = '0;
  endfunction

  function automatic ipms_pkg::out_t step_power_mode(ipms_pkg::in_t st);
    ipms_pkg::out_t                  r;
    logic [2:0]                      start;
    logic                            poll;
    logic [ipms_pkg::TIMER_BITS-1:0] lim;
    r     = '0;
    start = mode_q;
    poll  = 1'b0;
    if (st.bus_sleep_write) permit_q = st.bus_sleep_value;
    if (mode_q == ipms_pkg::PM_SLEEP) begin
      poll = 1'b1;
    end else begin
      if (st.ign_volt > cfg_q.err_high || st.ign_volt < cfg_q.err_low) fault_q = 1'b1;
      // clear test last, so it wins when the windows overlap
      if (st.ign_volt < cfg_q.ok_high && st.ign_volt > cfg_q.ok_low) fault_q = 1'b0;
      if (!fault_q) begin
        fault_tmr = '0;
        good_tmr  = timer_add(good_tmr, st.elapsed_ms);
        if (good_tmr >= ipms_pkg::GOOD_DWELL_MS) qual_q = 1'b1;
      end else begin
        lim       = (st.ign_volt > cfg_q.ok_high) ? cfg_q.high_fault_ms : cfg_q.low_fault_ms;
        fault_tmr = timer_add(fault_tmr, st.elapsed_ms);
        if (fault_tmr >= lim) qual_q = 1'b0;
        good_tmr = '0;
      end
      case (mode_q)
        ipms_pkg::PM_WORK: begin
          if (!qual_q) mode_q = ipms_pkg::PM_OFF;
        end
        ipms_pkg::PM_OFF: begin
          if (qual_q) mode_q = ipms_pkg::PM_WORK;
          if (st.app_sleep_ok && st.ign_volt < cfg_q.sleep_volt) begin
            r.net_release = 1'b1;
            mode_q        = ipms_pkg::PM_STANDBY;
          end
        end
        ipms_pkg::PM_STANDBY: begin
          if (qual_q) begin
            r.net_request = 1'b1;
            permit_q      = 1'b0;
            mode_q        = ipms_pkg::PM_WORK;
          end
          if (!st.app_sleep_ok) begin
            r.net_request = 1'b1;
            permit_q      = 1'b0;
            mode_q        = ipms_pkg::PM_OFF;
          end
          if (permit_q) begin
            mode_q          = ipms_pkg::PM_WAIT;
            mode_tmr        = '0;
            r.bus_sleep_cmd = 1'b1;
          end
        end
        ipms_pkg::PM_WAIT: begin
          mode_tmr = timer_add(mode_tmr, st.elapsed_ms);
          if (mode_tmr >= ipms_pkg::WAIT_DWELL_MS) begin
            mode_q = ipms_pkg::PM_SLEEP;
            poll   = 1'b1;
          end
        end
        default: begin
          mode_tmr = timer_add(mode_tmr, st.elapsed_ms);
          if (mode_tmr >= ipms_pkg::INIT_DWELL_MS)
            mode_q = qual_q ? ipms_pkg::PM_WORK : ipms_pkg::PM_OFF;
        end
      endcase
    end
    if (poll) begin
      if (st.bus_wake) begin
        mode_q         = ipms_pkg::PM_INIT;
        r.bus_wake_cmd = 1'b1;
        permit_q       = 1'b0;
        mode_tmr       = '0;
      end else if (st.ign_volt > cfg_q.wake_volt) begin
        clear_seq_state();
        r.wake_reset = 1'b1;
      end
    end
    r.power_mode   = mode_q;
    r.ign_good     = qual_q;
    r.mode_changed = (mode_q != start);
    return r;
  endfunction

  // result checker
  task automatic check_field(string name, int got, int want);
    if (got != want)
      flag_error($sformatf("beat %0d %s: got %0d, want %0d", result_idx, name, got, want));
  endtask

  always @(posedge clk) begin
    ipms_pkg::out_t got;
    ipms_pkg::out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[ipms_pkg::OUT_BITS-1:0];
      if (m_tdata[ipms_pkg::OUT_TDATA_BITS-1:ipms_pkg::OUT_BITS] != '0)
        flag_error($sformatf("beat %0d: padding bits not zero", result_idx));
      if (pending_results.size() == 0) begin
        flag_error($sformatf("beat %0d: result with nothing expected", result_idx));
      end else begin
        want = pending_results.pop_front();
        check_field("power_mode", got.power_mode, want.power_mode);
        check_field("ign_good", got.ign_good, want.ign_good);
        check_field("mode_changed", got.mode_changed, want.mode_changed);
        check_field("net_request", got.net_request, want.net_request);
        check_field("net_release", got.net_release, want.net_release);
        check_field("bus_sleep_cmd", got.bus_sleep_cmd, want.bus_sleep_cmd);
        check_field("bus_wake_cmd", got.bus_wake_cmd, want.bus_wake_cmd);
        check_field("wake_reset", got.wake_reset, want.wake_reset);
      end
      result_idx++;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_step(ipms_pkg::in_t st);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= st;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(step_power_mode(st));
  endtask

  task automatic settle();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [ipms_pkg::IDX_BITS-1:0] idx,
                           logic [ipms_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ipms_pkg::CFG_ERR_HIGH:   cfg_q.err_high      = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_ERR_LOW:    cfg_q.err_low       = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_OK_HIGH:    cfg_q.ok_high       = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_OK_LOW:     cfg_q.ok_low        = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_SLEEP_VOLT: cfg_q.sleep_volt    = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_WAKE_VOLT:  cfg_q.wake_volt     = data[ipms_pkg::VOLT_BITS-1:0];
      ipms_pkg::CFG_HIGH_FAULT: cfg_q.high_fault_ms = data;
      ipms_pkg::CFG_LOW_FAULT:  cfg_q.low_fault_ms  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // voltage registers get random junk above bit 11
  task automatic write_all(ipms_pkg::cfg_t c);
    write_reg(ipms_pkg::CFG_ERR_HIGH, {4'($urandom), c.err_high});
    write_reg(ipms_pkg::CFG_ERR_LOW, {4'($urandom), c.err_low});
    write_reg(ipms_pkg::CFG_OK_HIGH, {4'($urandom), c.ok_high});
    write_reg(ipms_pkg::CFG_OK_LOW, {4'($urandom), c.ok_low});
    write_reg(ipms_pkg::CFG_SLEEP_VOLT, {4'($urandom), c.sleep_volt});
    write_reg(ipms_pkg::CFG_WAKE_VOLT, {4'($urandom), c.wake_volt});
    write_reg(ipms_pkg::CFG_HIGH_FAULT, c.high_fault_ms);
    write_reg(ipms_pkg::CFG_LOW_FAULT, c.low_fault_ms);
  endtask

  function automatic ipms_pkg::in_t make_step(int v, int el, bit app, bit bw, bit bv, bit wake);
    ipms_pkg::in_t st;
    st.ign_volt        = ipms_pkg::VOLT_BITS'(v);
    st.elapsed_ms      = ipms_pkg::EL_BITS'(el);
    st.app_sleep_ok    = app;
    st.bus_sleep_write = bw;
    st.bus_sleep_value = bv;
    st.bus_wake        = wake;
    return st;
  endfunction

  function automatic int pick_between(int lo, int hi);
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (hi < lo) return $urandom_range(4095);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int rand_volt(volt_class_t c);
    int t;
    case ($urandom_range(5))
      0: t = cfg_q.err_high;
      1: t = cfg_q.err_low;
      2: t = cfg_q.ok_high;
      3: t = cfg_q.ok_low;
      4: t = cfg_q.sleep_volt;
      default: t = cfg_q.wake_volt;
    endcase
    case (c)
      VC_GOOD:     return pick_between(int'(cfg_q.ok_low) + 1, int'(cfg_q.ok_high) - 1);
      VC_LOW_ERR:  return pick_between(0, int'(cfg_q.err_low) - 1);
      VC_HIGH_ERR: return pick_between(int'(cfg_q.err_high) + 1, 4095);
      VC_SLEEPY:   return pick_between(0, int'(cfg_q.sleep_volt) - 1);
      VC_WAKE:     return pick_between(int'(cfg_q.wake_volt) + 1, 4095);
      VC_NEAR:     return pick_between(t - 2, t + 2);
      default:     return $urandom_range(4095);
    endcase
  endfunction

  function automatic ipms_pkg::in_t rand_step(step_profile_t prof);
    ipms_pkg::in_t st;
    st = ipms_pkg::IN_BITS'($urandom);
    case (prof)
      PROF_SLEEP: begin
        st.ign_volt        = ipms_pkg::VOLT_BITS'(
                               rand_volt($urandom_range(99) < 85 ? VC_SLEEPY : VC_ANY));
        st.app_sleep_ok    = ($urandom_range(9) != 0);
        st.bus_sleep_write = ($urandom_range(3) == 0);
        st.bus_sleep_value = ($urandom_range(4) != 0);
        st.bus_wake        = ($urandom_range(9) == 0);
      end
      PROF_DRIVE: begin
        st.ign_volt        = ipms_pkg::VOLT_BITS'(
                               rand_volt($urandom_range(99) < 80 ? VC_GOOD : VC_NEAR));
        st.bus_sleep_write = ($urandom_range(9) == 0);
        st.bus_wake        = ($urandom_range(19) == 0);
      end
      default: ;
    endcase
    return st;
  endfunction

  function automatic ipms_pkg::cfg_t rand_sane_cfg();
    ipms_pkg::cfg_t c;
    c.err_low       = ipms_pkg::VOLT_BITS'($urandom_range(1200, 200));
    c.ok_low        = c.err_low + ipms_pkg::VOLT_BITS'($urandom_range(200));
    c.ok_high       = ipms_pkg::VOLT_BITS'($urandom_range(3500, 2500));
    c.err_high      = c.ok_high + ipms_pkg::VOLT_BITS'($urandom_range(200));
    c.sleep_volt    = ipms_pkg::VOLT_BITS'($urandom_range(int'(c.err_low), 100));
    c.wake_volt     = c.sleep_volt + ipms_pkg::VOLT_BITS'($urandom_range(800));
    c.high_fault_ms = ipms_pkg::TIMER_BITS'($urandom_range(600));
    c.low_fault_ms  = ipms_pkg::TIMER_BITS'($urandom_range(600));
    return c;
  endfunction

  task automatic run_random_phase(int count, int idle, int stall);
    int sent;
    int len;
    int pick;
    step_profile_t prof;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      prof = (pick < 55) ? PROF_SLEEP : (pick < 85) ? PROF_DRIVE : PROF_NOISE;
      len  = $urandom_range(30, 3);
      repeat (len) send_step(rand_step(prof));
      sent += len;
    end
  endtask

  // full init -> off -> standby -> wait -> sleep loop, both wake sources
  task automatic test_mode_paths();
    idle_pct  = 0;
    stall_pct = 0;
    send_step(make_step(300, 255, 1, 0, 0, 0));
    send_step(make_step(300, 255, 1, 0, 0, 0));
    send_step(make_step(300, 10, 1, 0, 0, 0));
    send_step(make_step(300, 10, 1, 1, 1, 0));
    send_step(make_step(300, 120, 1, 0, 0, 0));
    send_step(make_step(4000, 255, 1, 0, 0, 1));   // bus wake beats ignition wake
    send_step(make_step(300, 255, 1, 0, 0, 0));
    send_step(make_step(300, 255, 1, 0, 0, 0));
    send_step(make_step(300, 10, 1, 0, 0, 0));
    send_step(make_step(300, 10, 1, 1, 1, 0));
    send_step(make_step(300, 255, 1, 0, 0, 0));
    send_step(make_step(3000, 0, 1, 0, 0, 0));     // ignition wake reset
    send_step(make_step(2000, 255, 0, 0, 0, 1));   // bus wake outside sleep
    send_step(make_step(2000, 255, 0, 0, 0, 1));
    settle();
    write_reg(ipms_pkg::CFG_SLEEP_VOLT, 16'd2000);
    send_step(make_step(4000, 255, 0, 0, 0, 0));
    send_step(make_step(4000, 255, 0, 0, 0, 0));
    send_step(make_step(1500, 100, 1, 0, 0, 0));   // off -> work -> standby
    send_step(make_step(1500, 0, 0, 1, 1, 0));     // standby left twice
    settle();
    write_reg(ipms_pkg::CFG_SLEEP_VOLT, 16'd500);
  endtask

  task automatic test_field_extremes();
    send_step(make_step(0, 0, 0, 0, 0, 0));
    send_step(make_step(4095, 255, 1, 1, 1, 1));
    send_step(make_step(3200, 1, 0, 1, 0, 0));
    send_step(make_step(3201, 1, 1, 0, 1, 0));
    send_step(make_step(899, 1, 0, 0, 0, 1));
    send_step(make_step(900, 1, 1, 1, 0, 0));
    send_step(make_step(3100, 1, 0, 0, 1, 0));
    send_step(make_step(950, 1, 1, 0, 0, 0));
    send_step(make_step(951, 200, 0, 0, 0, 0));
    send_step(make_step(3099, 255, 1, 0, 0, 0));
    settle();
  endtask

  // fault and clear windows overlap: the clear wins
  task automatic test_hysteresis_overlap();
    write_reg(ipms_pkg::CFG_ERR_LOW, 16'd2000);
    write_reg(ipms_pkg::CFG_ERR_HIGH, 16'd2500);
    send_step(make_step(1500, 50, 0, 0, 0, 0));
    send_step(make_step(2800, 50, 0, 0, 0, 0));
    send_step(make_step(800, 200, 0, 0, 0, 0));
    send_step(make_step(1500, 200, 0, 0, 0, 0));
    settle();
    write_reg(ipms_pkg::CFG_ERR_LOW, 16'd900);
    write_reg(ipms_pkg::CFG_ERR_HIGH, 16'd3200);
  endtask

  task automatic test_config_regs();
    int i;
    for (i = int'(ipms_pkg::CFG_LOW_FAULT) + 1; i < 16; i++)
      write_reg(ipms_pkg::IDX_BITS'(i), 16'($urandom));
    write_all(rand_sane_cfg());
    repeat (20) send_step(rand_step(PROF_DRIVE));
    settle();
    write_all(ipms_pkg::CFG_RESET);
  endtask

  // both dwell timers run into their saturation value
  task automatic test_dwell_saturation();
    write_reg(ipms_pkg::CFG_HIGH_FAULT, 16'hFFFF);
    repeat (260) send_step(make_step(2000, 255, 0, 0, 0, 0));
    repeat (260) send_step(make_step(4095, 255, 0, 0, 0, 0));
    settle();
    write_reg(ipms_pkg::CFG_HIGH_FAULT, 16'd300);
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 400;
    repeat (40) send_step(rand_step(PROF_DRIVE));
    settle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(150, 0, 0);
    settle();
    write_all(rand_sane_cfg());
    run_random_phase(150, 51, 0);
    settle();
    write_all('0);
    run_random_phase(150, 0, 51);
    settle();
    write_all('1);
    run_random_phase(150, 25, 25);
    settle();
    write_all(rand_sane_cfg());
    run_random_phase(150, 25, 25);
    settle();
    write_all(ipms_pkg::CFG_RESET);
    run_random_phase(150, 0, 0);
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cfg_q     = ipms_pkg::CFG_RESET;
    clear_seq_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_mode_paths();
    test_field_extremes();
    test_hysteresis_overlap();
    test_config_regs();
    test_dwell_saturation();
    test_backpressure();
    test_random_traffic();
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
